// ----- rtl/core/dbd_pkg.sv -----
// Shared types, constants and calendar table for the days-between-dates block.
package dbd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DAYS_W  = 22;
	localparam int DNUM_W  = 23;
	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 13;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int C100_W  = 8;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^15
	localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
	localparam int                 RECIP_SHIFT = 19;
	localparam logic [MUL_B_W-1:0] CENTURY     = 13'd100;
	localparam logic [MUL_B_W-1:0] YEAR_DAYS   = 13'd365;
	localparam logic [YEAR_W:0]    CENT_BIAS   = 15'd99;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_C100,
		ST_CHK,
		ST_Y365,
		ST_ACC
	} dbd_state_t;

	// Days before the first of the month; month zero reads as January, above twelve as December.
	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:       r = 9'd31;
			4'd3:       r = 9'd59;
			4'd4:       r = 9'd90;
			4'd5:       r = 9'd120;
			4'd6:       r = 9'd151;
			4'd7:       r = 9'd181;
			4'd8:       r = 9'd212;
			4'd9:       r = 9'd243;
			4'd10:      r = 9'd273;
			4'd11:      r = 9'd304;
			default:    r = 9'd334;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/dbd_mul.sv -----
// Shared registered multiplier used by every step of the day-number sequence.
module dbd_mul
	import dbd_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ----- rtl/core/days_between_dates.sv -----
// Days between two Gregorian dates, by iterative day-number conversion.
//
// Input channel (in_valid / in_ready) carries two dates: year, month, day each.
// Output channel (out_valid / out_ready) carries days_apart, the absolute
// distance in days, saturated at the all-ones value of the field.
// Both channels transfer on a clock edge where valid and ready are high.
//
// Each date goes through four steps on one shared multiplier: the century
// ceiling by reciprocal, the century check, 365 times the year, and the
// final sum. Date A is converted first and then date B, and a new item is
// accepted in the same cycle the result appears.
// in_ready is high only while the sequencer is idle.
// If the previous result has not been taken when the next finishes, the
// sequencer holds in its last step until out_ready frees the output register.
// Reset (arst_n low) idles the sequencer and drops out_valid; no clearing
// pass is needed.
module days_between_dates
	import dbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [YEAR_W-1:0]  year_a,
	input  logic [MONTH_W-1:0] month_a,
	input  logic [DAY_W-1:0]   day_a,
	input  logic [YEAR_W-1:0]  year_b,
	input  logic [MONTH_W-1:0] month_b,
	input  logic [DAY_W-1:0]   day_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DAYS_W-1:0]  days_apart
);

	dbd_state_t state_q, state_d;
	logic sel_q, sel_d;
	logic out_valid_q, out_valid_d;

	logic [YEAR_W-1:0]  ya_q, yb_q;
	logic [MONTH_W-1:0] ma_q, mb_q;
	logic [DAY_W-1:0]   da_q, db_q;
	logic [C100_W-1:0]  c100_q;
	logic               cent_q;
	logic [DNUM_W-1:0]  na_q;
	logic [DAYS_W-1:0]  days_q;

	logic [YEAR_W-1:0]  y;
	logic [MONTH_W-1:0] m;
	logic [DAY_W-1:0]   d;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [C100_W-1:0]  c100_new;
	logic [C100_W-1:0]  c400;
	logic [YEAR_W-2:0]  q4;
	logic               leap;
	logic [DNUM_W-1:0]  n_cur;
	logic [DNUM_W-1:0]  diff;
	logic               out_free;

	dbd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign y = sel_q ? yb_q : ya_q;
	assign m = sel_q ? mb_q : ma_q;
	assign d = sel_q ? db_q : da_q;

	assign c100_new = prod[RECIP_SHIFT +: C100_W];
	assign c400     = C100_W'((9'(c100_q) + 9'd3) >> 2);
	assign q4       = (YEAR_W-1)'(((YEAR_W+1)'(y) + (YEAR_W+1)'(3)) >> 2);
	// leap: divisible by 4, and not a century unless the century count is a multiple of 4
	assign leap     = (y[1:0] == 2'b00) && (!cent_q || (c100_q[1:0] == 2'b00));

	always_comb begin
		n_cur = prod[DNUM_W-1:0]
			+ DNUM_W'(q4)
			- DNUM_W'(c100_q)
			+ DNUM_W'(c400)
			+ DNUM_W'(days_before_month(m))
			+ DNUM_W'((m > 4'd2) && leap)
			+ DNUM_W'(d);
		diff = (na_q >= n_cur) ? (na_q - n_cur) : (n_cur - na_q);
	end

	assign out_free = !out_valid_q || out_ready;

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_C100: begin
				mul_a = MUL_A_W'(y) + CENT_BIAS;
				mul_b = RECIP_100;
			end
			ST_CHK: begin
				mul_a = MUL_A_W'(c100_new);
				mul_b = CENTURY;
			end
			ST_Y365, ST_ACC: begin
				mul_a = MUL_A_W'(y);
				mul_b = YEAR_DAYS;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_C100;
					sel_d   = 1'b0;
				end
			end
			ST_C100: state_d = ST_CHK;
			ST_CHK:  state_d = ST_Y365;
			ST_Y365: state_d = ST_ACC;
			ST_ACC: begin
				if (!sel_q) begin
					state_d = ST_C100;
					sel_d   = 1'b1;
				end else if (out_free) begin
					state_d     = ST_IDLE;
					out_valid_d = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ya_q <= year_a;
			ma_q <= month_a;
			da_q <= day_a;
			yb_q <= year_b;
			mb_q <= month_b;
			db_q <= day_b;
		end
		if (state_q == ST_CHK) begin
			c100_q <= c100_new;
		end
		if (state_q == ST_Y365) begin
			cent_q <= (prod == PROD_W'(y));
		end
		if (state_q == ST_ACC && !sel_q) begin
			na_q <= n_cur;
		end
		// saturate distances beyond the field
		if (state_q == ST_ACC && sel_q && out_free) begin
			days_q <= diff[DNUM_W-1] ? {DAYS_W{1'b1}} : diff[DAYS_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign days_apart = days_q;

endmodule

// ----- rtl/core/dbd_checker.sv -----
// Port-level checks for the days-between-dates block, bound to the top level.
module dbd_checker
	import dbd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [YEAR_W-1:0]  year_a,
	input logic [MONTH_W-1:0] month_a,
	input logic [DAY_W-1:0]   day_a,
	input logic [YEAR_W-1:0]  year_b,
	input logic [MONTH_W-1:0] month_b,
	input logic [DAY_W-1:0]   day_b,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DAYS_W-1:0]  days_apart
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(days_apart))
		else $error("result changed or dropped while stalled");

	// the sequencer stays busy after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input accepted again too early");

	// a new result frees the input side in the same cycle
	a_rose_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while sequencer still busy");

	// no result appears right after a transfer in
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after transfer in");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (.*);
